### rtl/odrd_pkg.sv
`timescale 1ns / 1ps
package odrd_pkg;

  localparam int NodeLimit = 16;
  localparam int NodeAw = $clog2(NodeLimit);
  localparam int SeenDepth = 32;
  localparam int SeenAw = $clog2(SeenDepth);

  localparam logic [2:0] CMD_SEND = 3'd0;
  localparam logic [2:0] CMD_RREQ = 3'd1;
  localparam logic [2:0] CMD_RREP = 3'd2;
  localparam logic [2:0] CMD_DATA = 3'd3;
  localparam logic [2:0] CMD_NBR  = 3'd4;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_RREQ    = 3'd1;
  localparam logic [2:0] ACT_RREP    = 3'd2;
  localparam logic [2:0] ACT_FWD     = 3'd3;
  localparam logic [2:0] ACT_DELIVER = 3'd4;
  localparam logic [2:0] ACT_INSTALL = 3'd5;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  hop_count;
    logic [3:0]  dest_node;
    logic [15:0] dest_seqnum;
    logic [3:0]  origin_node;
    logic [15:0] origin_seq;
    logic [3:0]  from_node;
    logic [15:0] neighbor_mask;
  } item_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  target_node;
    logic [7:0]  hop_out;
    logic [3:0]  dest_out;
    logic [15:0] dest_seq_out;
    logic [3:0]  origin_out;
    logic [15:0] origin_seq_out;
  } item_out_t;

  // classified item passed from front to back
  typedef struct packed {
    item_in_t  item;
    logic      is_me_dst;
    logic      is_me_org;
  } work_t;

endpackage

### rtl/odrd_front.sv
`timescale 1ns / 1ps
module odrd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        own_id,
  input  logic              push,
  output logic              full,
  input  odrd_pkg::item_in_t in_item,
  output logic              q_valid,
  input  logic              q_take,
  output odrd_pkg::work_t   q_data
);
  import odrd_pkg::*;

  // two-entry queue between front and back
  work_t       slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  work_t       cls;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    cls.item = in_item;
    cls.is_me_dst = (in_item.dest_node == own_id);
    cls.is_me_org = (in_item.origin_node == own_id);
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

### rtl/odrd_back.sv
`timescale 1ns / 1ps
module odrd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         own_id,
  input  logic               q_valid,
  output logic               q_take,
  input  odrd_pkg::work_t    q_data,
  output logic               empty,
  input  logic               pop,
  output odrd_pkg::item_out_t out_item
);
  import odrd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;
  work_t  w;

  logic [NodeLimit-1:0] route_valid;
  logic [3:0]  route_next [NodeLimit];
  logic [7:0]  route_hops [NodeLimit];
  logic [15:0] route_seq  [NodeLimit];

  // seen ring is a memory scanned one entry per cycle
  logic [SeenDepth-1:0] seen_valid;
  logic [27:0] seen_mem [SeenDepth];
  logic [27:0] rd_data;
  logic [SeenAw-1:0] rd_addr;
  logic [SeenAw:0]   scan_cnt;
  logic              rd_live;
  logic [SeenAw-1:0] rd_idx;
  logic [SeenAw-1:0] seen_wp;
  logic [15:0] orig_cnt;
  logic [15:0] reply_cnt;
  logic dup;
  logic found;
  logic [3:0] back;

  item_out_t res;
  item_out_t res_next;
  logic [7:0] hop_inc;
  logic [7:0] hop_dec;
  logic back_nbr;

  assign q_take = (state == ST_IDLE) && q_valid;
  assign empty  = (state != ST_OUT);
  assign hop_inc = (w.item.hop_count == 8'hff) ? 8'hff : w.item.hop_count + 8'd1;
  assign hop_dec = (w.item.hop_count == 8'h00) ? 8'h00 : w.item.hop_count - 8'd1;
  assign back_nbr = (back != own_id) && w.item.neighbor_mask[back];
  assign rd_addr = seen_wp + scan_cnt[SeenAw-1:0];

  always_ff @(posedge clk) begin
    rd_data <= seen_mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  // result of the item under execution
  always_comb begin
    res_next = '0;
    unique case (w.item.command)
      CMD_SEND, CMD_DATA: begin
        if (w.item.command == CMD_DATA && w.is_me_dst) begin
          res_next = '{ACT_DELIVER, w.item.origin_node, 8'd0, w.item.dest_node,
                       16'd0, w.item.origin_node, 16'd0};
        end else if (w.item.command == CMD_SEND && w.is_me_dst) begin
          res_next = '0;
        end else if (route_valid[w.item.dest_node]) begin
          res_next = '{ACT_FWD, route_next[w.item.dest_node], 8'd0,
                       w.item.dest_node, 16'd0,
                       (w.item.command == CMD_SEND) ? own_id : w.item.origin_node,
                       16'd0};
        end else begin
          res_next = '{ACT_RREQ, 4'd0, 8'd1, w.item.dest_node, 16'd1, own_id,
                       orig_cnt + 16'd1};
        end
      end
      CMD_RREQ: begin
        if (!w.is_me_org && !dup) begin
          if (w.is_me_dst) begin
            res_next = '{ACT_RREP, w.item.from_node, w.item.hop_count, own_id,
                         reply_cnt + 16'd1, w.item.origin_node, w.item.origin_seq};
          end else begin
            res_next = '{ACT_RREQ, 4'd0, hop_inc, w.item.dest_node,
                         w.item.dest_seqnum, w.item.origin_node, w.item.origin_seq};
          end
        end
      end
      CMD_RREP: begin
        if (w.is_me_org) begin
          res_next = '{ACT_INSTALL, w.item.from_node, w.item.hop_count,
                       w.item.dest_node, w.item.dest_seqnum, w.item.origin_node,
                       w.item.origin_seq};
        end else if (found && back_nbr) begin
          res_next = '{ACT_RREP, back, hop_dec, w.item.dest_node,
                       w.item.dest_seqnum, w.item.origin_node, w.item.origin_seq};
        end
      end
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      route_valid <= '0;
      seen_valid  <= '0;
      seen_wp     <= '0;
      orig_cnt    <= '0;
      reply_cnt   <= '0;
      rd_live     <= 1'b0;
      scan_cnt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            w        <= q_data;
            state    <= ST_SCAN;
            scan_cnt <= '0;
            rd_live  <= 1'b0;
            dup      <= 1'b0;
            found    <= 1'b0;
            back     <= '0;
          end
        end
        ST_SCAN: begin
          // oldest to newest so the newest match wins
          if (rd_live && seen_valid[rd_idx] &&
              rd_data[27:24] == w.item.origin_node &&
              rd_data[23:20] == w.item.dest_node) begin
            if (w.item.origin_seq <= rd_data[19:4]) dup <= 1'b1;
            if (w.item.origin_seq == rd_data[19:4]) begin
              found <= 1'b1;
              back  <= rd_data[3:0];
            end
          end
          rd_live <= !scan_cnt[SeenAw];
          if (scan_cnt[SeenAw] && rd_live == 1'b0) state <= ST_EXEC;
          if (!scan_cnt[SeenAw]) scan_cnt <= scan_cnt + 1'b1;
          if (w.item.command != CMD_RREQ && w.item.command != CMD_RREP)
            state <= ST_EXEC;
        end
        ST_EXEC: begin
          res   <= res_next;
          state <= ST_OUT;
          unique case (w.item.command)
            CMD_SEND, CMD_DATA: begin
              if (!w.is_me_dst && !route_valid[w.item.dest_node])
                orig_cnt <= orig_cnt + 16'd1;
            end
            CMD_RREQ: begin
              if (!w.is_me_org && !dup) begin
                seen_valid[seen_wp] <= 1'b1;
                seen_mem[seen_wp] <= {w.item.origin_node, w.item.dest_node,
                                      w.item.origin_seq, w.item.from_node};
                seen_wp <= seen_wp + 1'b1;
                if (w.is_me_dst) reply_cnt <= reply_cnt + 16'd1;
              end
            end
            CMD_RREP: begin
              if (w.is_me_org) begin
                route_valid[w.item.dest_node] <= 1'b1;
                route_next[w.item.dest_node]  <= w.item.from_node;
                route_hops[w.item.dest_node]  <= w.item.hop_count;
                route_seq[w.item.dest_node]   <= w.item.dest_seqnum;
              end else if (found && back_nbr) begin
                route_valid[w.item.dest_node] <= 1'b1;
                route_next[w.item.dest_node]  <= w.item.from_node;
                route_hops[w.item.dest_node]  <= hop_dec;
                route_seq[w.item.dest_node]   <= w.item.dest_seqnum;
              end
            end
            CMD_NBR: begin
              for (int n = 0; n < NodeLimit; n++) begin
                if (route_next[NodeAw'(n)] == own_id ||
                    !w.item.neighbor_mask[route_next[NodeAw'(n)]])
                  route_valid[NodeAw'(n)] <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          if (pop) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_item = res;
endmodule

### rtl/ondemand_route_discovery_node.sv
`timescale 1ns / 1ps
// one node's route discovery control plane
// input channel: push / full carries one event per transfer (in_item struct)
// result channel: empty / pop carries exactly one result per event, in order
// config: own_id_we / own_id_wdata write the node id, only while idle
// a two-entry queue decouples the accepting front from the executing back
// send, data, neighbor and unknown events pass from the scan state straight
// to exec, which registers the result, and then to the out state
// rreq and rrep events scan the 32-entry seen ring one entry a cycle through
// the registered memory read before exec registers the result; the back
// takes no new event until its result is popped
// the back holds its result until popped; the front keeps taking events
// until its queue is full, then full stays high
// reset clears routes, seen ring valid bits, pointer and both counters
// and sets own_id to zero
module ondemand_route_discovery_node (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  odrd_pkg::item_in_t  in_item,
  output logic                empty,
  input  logic                pop,
  output odrd_pkg::item_out_t out_item,
  input  logic                own_id_we,
  input  logic [3:0]          own_id_wdata
);
  import odrd_pkg::*;

  logic [3:0] own_id;
  logic       q_valid;
  logic       q_take;
  work_t      q_data;

  // node id register
  always_ff @(posedge clk) begin
    if (rst) own_id <= '0;
    else if (own_id_we) own_id <= own_id_wdata;
  end

  odrd_front u_front (
    .clk(clk), .rst(rst), .own_id(own_id), .push(push), .full(full),
    .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  odrd_back u_back (
    .clk(clk), .rst(rst), .own_id(own_id), .q_valid(q_valid), .q_take(q_take),
    .q_data(q_data), .empty(empty), .pop(pop), .out_item(out_item)
  );
endmodule

### rtl/odrd_checker.sv
`timescale 1ns / 1ps
module odrd_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input odrd_pkg::item_out_t out_item
);
  import odrd_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");
  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while waiting");
  a_act: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.action <= ACT_INSTALL))
    else $error("bad action");
endmodule

bind ondemand_route_discovery_node odrd_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item)
);

### test/ondemand_route_discovery_node_test.sv
`timescale 1ns / 1ps
module ondemand_route_discovery_node_test;
  import odrd_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int RandomItems = 1100;
  localparam int DrainCycles = 60;
  localparam int InBits = $bits(item_in_t);

  // node state tracker: routes, seen ring, counters and the queue of expected results
  class route_board;
    logic [3:0]  own;
    bit          rt_valid[NodeLimit];
    logic [3:0]  rt_next[NodeLimit];
    logic [7:0]  rt_hops[NodeLimit];
    logic [15:0] rt_seq[NodeLimit];
    bit          sn_valid[SeenDepth];
    logic [3:0]  sn_org[SeenDepth];
    logic [3:0]  sn_dst[SeenDepth];
    logic [15:0] sn_seq[SeenDepth];
    logic [3:0]  sn_from[SeenDepth];
    int          sn_ptr;
    logic [15:0] orig_cnt;
    logic [15:0] reply_cnt;
    item_out_t   awaited[$];
    int          errors;

    function new();
      own = '0;
      sn_ptr = 0;
      orig_cnt = '0;
      reply_cnt = '0;
      errors = 0;
      foreach (rt_valid[i]) rt_valid[i] = 0;
      foreach (sn_valid[i]) sn_valid[i] = 0;
    endfunction

    function bit is_nbr(logic [3:0] node, logic [15:0] mask);
      return (node != own) && mask[node];
    endfunction

    // forward if a route is known, else originate a discovery
    function item_out_t toward(logic [3:0] dst, logic [3:0] org);
      item_out_t r;
      r = '0;
      if (rt_valid[dst]) begin
        r.action = ACT_FWD;
        r.target_node = rt_next[dst];
        r.dest_out = dst;
        r.origin_out = org;
      end else begin
        orig_cnt = orig_cnt + 16'd1;
        r.action = ACT_RREQ;
        r.hop_out = 8'd1;
        r.dest_out = dst;
        r.dest_seq_out = 16'd1;
        r.origin_out = own;
        r.origin_seq_out = orig_cnt;
      end
      return r;
    endfunction

    // note an accepted input event and queue the result it causes
    function void note(item_in_t it);
      item_out_t r;
      bit dup, found;
      logic [3:0] back;
      logic [7:0] nh;
      int idx;
      r = '0;
      case (it.command)
        CMD_SEND: begin
          if (it.dest_node != own) r = toward(it.dest_node, own);
        end
        CMD_RREQ: begin
          dup = 0;
          if (it.origin_node != own) begin
            for (int i = 0; i < SeenDepth; i++)
              if (sn_valid[i] && sn_org[i] == it.origin_node && sn_dst[i] == it.dest_node &&
                  it.origin_seq <= sn_seq[i]) dup = 1;
            if (!dup) begin
              sn_valid[sn_ptr] = 1;
              sn_org[sn_ptr] = it.origin_node;
              sn_dst[sn_ptr] = it.dest_node;
              sn_seq[sn_ptr] = it.origin_seq;
              sn_from[sn_ptr] = it.from_node;
              sn_ptr = (sn_ptr + 1) % SeenDepth;
              if (it.dest_node == own) begin
                reply_cnt = reply_cnt + 16'd1;
                r.action = ACT_RREP;
                r.target_node = it.from_node;
                r.hop_out = it.hop_count;
                r.dest_out = own;
                r.dest_seq_out = reply_cnt;
              end else begin
                r.action = ACT_RREQ;
                r.hop_out = (it.hop_count == 8'hff) ? 8'hff : it.hop_count + 8'd1;
                r.dest_out = it.dest_node;
                r.dest_seq_out = it.dest_seqnum;
              end
              r.origin_out = it.origin_node;
              r.origin_seq_out = it.origin_seq;
            end
          end
        end
        CMD_RREP: begin
          if (it.origin_node == own) begin
            rt_valid[it.dest_node] = 1;
            rt_next[it.dest_node] = it.from_node;
            rt_hops[it.dest_node] = it.hop_count;
            rt_seq[it.dest_node] = it.dest_seqnum;
            r.action = ACT_INSTALL;
            r.target_node = it.from_node;
            r.hop_out = it.hop_count;
            r.dest_out = it.dest_node;
            r.dest_seq_out = it.dest_seqnum;
            r.origin_out = it.origin_node;
            r.origin_seq_out = it.origin_seq;
          end else begin
            found = 0;
            back = '0;
            nh = (it.hop_count == 8'd0) ? 8'd0 : it.hop_count - 8'd1;
            // oldest to newest, so the newest match wins
            for (int k = 0; k < SeenDepth; k++) begin
              idx = (sn_ptr + k) % SeenDepth;
              if (sn_valid[idx] && sn_dst[idx] == it.dest_node &&
                  sn_org[idx] == it.origin_node && sn_seq[idx] == it.origin_seq) begin
                found = 1;
                back = sn_from[idx];
              end
            end
            if (found && is_nbr(back, it.neighbor_mask)) begin
              rt_valid[it.dest_node] = 1;
              rt_next[it.dest_node] = it.from_node;
              rt_hops[it.dest_node] = nh;
              rt_seq[it.dest_node] = it.dest_seqnum;
              r.action = ACT_RREP;
              r.target_node = back;
              r.hop_out = nh;
              r.dest_out = it.dest_node;
              r.dest_seq_out = it.dest_seqnum;
              r.origin_out = it.origin_node;
              r.origin_seq_out = it.origin_seq;
            end
          end
        end
        CMD_DATA: begin
          if (it.dest_node == own) begin
            r.action = ACT_DELIVER;
            r.target_node = it.origin_node;
            r.dest_out = it.dest_node;
            r.origin_out = it.origin_node;
          end else begin
            r = toward(it.dest_node, it.origin_node);
          end
        end
        CMD_NBR: begin
          for (int i = 0; i < NodeLimit; i++)
            if (rt_valid[i] && !is_nbr(rt_next[i], it.neighbor_mask)) rt_valid[i] = 0;
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    // check one popped result against the oldest expectation
    function void check(item_out_t got);
      item_out_t e;
      if (awaited.size() == 0) begin
        $display("%0t unexpected result: expected nothing actual %0h", $time, got);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (e !== got) begin
        $display("%0t mismatch: expected %h actual %h", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  item_in_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  item_out_t out_item;
  logic      own_id_we = 1'b0;
  logic [3:0] own_id_wdata = '0;

  route_board board = new();
  item_in_t   recent_rreq[$];   // rreqs already sent, reused to build matching rreps
  int         cycles = 0;

  ondemand_route_discovery_node u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .own_id_we(own_id_we),
    .own_id_wdata(own_id_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall per result, then hold pop until a transfer
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      board.check(out_item);
    end
  end

  // one event transfer; push stays high across back-to-back events
  task automatic send_event(item_in_t it, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note(it);
    if (it.command == CMD_RREQ) begin
      recent_rreq.insert(recent_rreq.size(), it);
      if (recent_rreq.size() > 40) void'(recent_rreq.pop_front());
    end
  endtask

  // wait until all results are in and the block has gone quiet, then write own_id
  task automatic set_node_id(logic [3:0] id);
    push <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    own_id_we <= 1'b1;
    own_id_wdata <= id;
    @(posedge clk);
    own_id_we <= 1'b0;
    board.own = id;
    @(posedge clk);
  endtask

  function automatic item_in_t mk(logic [2:0] c, logic [7:0] h, logic [3:0] d,
                                  logic [15:0] ds, logic [3:0] o, logic [15:0] os,
                                  logic [3:0] f, logic [15:0] m);
    item_in_t it;
    it.command = c;
    it.hop_count = h;
    it.dest_node = d;
    it.dest_seqnum = ds;
    it.origin_node = o;
    it.origin_seq = os;
    it.from_node = f;
    it.neighbor_mask = m;
    return it;
  endfunction

  function automatic logic [3:0] pick_node();
    return ($urandom_range(0, 3) == 0) ? board.own : 4'($urandom_range(0, 15));
  endfunction

  // random event, mostly well-formed protocol traffic with small sequence ranges
  function automatic item_in_t rand_event();
    item_in_t it, src;
    int sel;
    it = '0;
    sel = $urandom_range(0, 99);
    it.hop_count = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) it.hop_count = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    it.dest_node = pick_node();
    it.origin_node = pick_node();
    it.from_node = 4'($urandom);
    it.dest_seqnum = 16'($urandom);
    it.origin_seq = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    it.neighbor_mask = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                   : 16'hffff ^ (16'd1 << $urandom_range(0, 15));
    if (sel < 15) begin
      it.command = CMD_SEND;
    end else if (sel < 40) begin
      it.command = CMD_RREQ;
    end else if (sel < 65) begin
      it.command = CMD_RREP;
      if (recent_rreq.size() > 0 && $urandom_range(0, 4) != 0) begin
        src = recent_rreq[$urandom_range(0, recent_rreq.size() - 1)];
        it.dest_node = src.dest_node;
        it.origin_node = src.origin_node;
        it.origin_seq = src.origin_seq;
      end
    end else if (sel < 82) begin
      it.command = CMD_DATA;
    end else if (sel < 90) begin
      it.command = CMD_NBR;
    end else if (sel < 95) begin
      it.command = 3'($urandom_range(5, 7));
    end else begin
      it = item_in_t'(InBits'({$urandom, $urandom, $urandom}));
    end
    return it;
  endfunction

  initial begin
    logic [3:0] ids[6];
    bit burst;
    ids = '{4'd15, 4'd5, 4'd0, 4'd9, 4'd15, 4'd3};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_node_id(4'd6);

    // directed: each protocol corner in turn
    send_event(mk(CMD_SEND, 8'd0, 4'd6, 16'd0, 4'd0, 16'd0, 4'd0, 16'd0), 0);  // send to self
    send_event(mk(CMD_SEND, 8'd0, 4'd2, 16'd0, 4'd0, 16'd0, 4'd0, 16'd0), 0);  // discovery
    send_event(mk(CMD_RREQ, 8'd3, 4'd6, 16'd7, 4'd1, 16'd4, 4'd3, 16'd0), 0);  // answered
    send_event(mk(CMD_RREQ, 8'd3, 4'd6, 16'd7, 4'd1, 16'd4, 4'd3, 16'd0), 1);  // duplicate
    send_event(mk(CMD_RREQ, 8'd1, 4'd2, 16'd0, 4'd6, 16'd9, 4'd3, 16'd0), 0);  // own rreq
    send_event(mk(CMD_RREQ, 8'hff, 4'd9, 16'hffff, 4'd4, 16'hffff, 4'd7, 16'hffff), 0);
    send_event(mk(CMD_RREP, 8'd0, 4'd2, 16'd11, 4'd6, 16'd1, 4'd5, 16'd0), 0); // install
    send_event(mk(CMD_SEND, 8'd0, 4'd2, 16'd0, 4'd0, 16'd0, 4'd0, 16'd0), 1);  // forward
    send_event(mk(CMD_DATA, 8'd0, 4'd6, 16'd0, 4'd8, 16'd0, 4'd1, 16'd0), 0);  // delivered
    send_event(mk(CMD_DATA, 8'd0, 4'd2, 16'd0, 4'd8, 16'd0, 4'd1, 16'd0), 0);  // transit
    send_event(mk(CMD_RREP, 8'd4, 4'd12, 16'd3, 4'd10, 16'd2, 4'd5, 16'hffff), 0); // no entry
    send_event(mk(CMD_RREP, 8'd0, 4'd9, 16'd5, 4'd4, 16'hffff, 4'd2, 16'h0000), 0); // no nbr
    send_event(mk(CMD_RREP, 8'd0, 4'd9, 16'd5, 4'd4, 16'hffff, 4'd2, 16'hffff), 0); // relay
    send_event(mk(CMD_RREQ, 8'd2, 4'd9, 16'd0, 4'd4, 16'd3, 4'd1, 16'd0), 0);  // stale seq
    send_event(mk(CMD_NBR, 8'd0, 4'd0, 16'd0, 4'd0, 16'd0, 4'd0, 16'h0020), 0); // drop some
    send_event(mk(CMD_SEND, 8'd0, 4'd9, 16'd0, 4'd0, 16'd0, 4'd0, 16'd0), 0);
    send_event(mk(CMD_NBR, 8'd0, 4'd0, 16'd0, 4'd0, 16'd0, 4'd0, 16'h0000), 0); // drop all
    send_event(mk(CMD_SEND, 8'd0, 4'd2, 16'd0, 4'd0, 16'd0, 4'd0, 16'd0), 1);
    send_event(mk(3'd5, 8'hff, 4'hf, 16'hffff, 4'hf, 16'hffff, 4'hf, 16'hffff), 0);
    send_event(mk(3'd6, 8'd0, 4'd0, 16'd0, 4'd0, 16'd0, 4'd0, 16'd0), 0);
    send_event(mk(3'd7, 8'hff, 4'hf, 16'hffff, 4'hf, 16'hffff, 4'hf, 16'hffff), 0);

    // random phases across several node ids, extremes included
    foreach (ids[p]) begin
      set_node_id(ids[p] == 4'd9 ? 4'($urandom) : ids[p]);
      for (int n = 0; n < RandomItems / 6; n++) begin
        burst = ($urandom_range(0, 3) == 0);
        send_event(rand_event(), burst);
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
